>>> rtl/ccs_pkg.sv
`timescale 1ns / 1ps

package ccs_pkg;

	localparam int WORD_W   = 32;
	localparam int NUM_WORD = 16;
	localparam int CFG_W    = 64;
	localparam int POS_W    = 6;
	localparam int NLEN_W   = 4;
	localparam int RND_W    = 5;
	// double rounds = ceil(rounds/2), at most 16
	localparam int DR_W     = RND_W;
	localparam int DRC_W    = DR_W - 1;

	// 16-byte block constant as four little-endian words
	localparam logic [WORD_W-1:0] SIGMA_0 = 32'h3632_3341;
	localparam logic [WORD_W-1:0] SIGMA_1 = 32'h7431_4C6F;
	localparam logic [WORD_W-1:0] SIGMA_2 = 32'h3072_5F33;
	localparam logic [WORD_W-1:0] SIGMA_3 = 32'h2135_4B43;

	localparam logic [NLEN_W-1:0] NLEN_RESET = 4'd12;
	localparam logic [RND_W-1:0]  RND_RESET  = 5'd20;

	typedef logic [NUM_WORD-1:0][WORD_W-1:0] word_arr_t;

	typedef enum logic [2:0] {
		REG_KEY_01     = 3'd0,
		REG_KEY_23     = 3'd1,
		REG_KEY_45     = 3'd2,
		REG_KEY_67     = 3'd3,
		REG_CTR_NONCE0 = 3'd4,
		REG_NONCE_12   = 3'd5,
		REG_NONCE_LEN  = 3'd6,
		REG_ROUNDS     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic abort;
	} eng_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_stat_t;

endpackage

>>> rtl/ccs_engine.sv
`timescale 1ns / 1ps

module ccs_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  ccs_pkg::eng_ctl_t  ctl,
	input  ccs_pkg::word_arr_t init,
	input  logic [ccs_pkg::DR_W-1:0] dbl_rounds,
	output ccs_pkg::eng_stat_t stat,
	output ccs_pkg::word_arr_t words
);
	import ccs_pkg::*;

	typedef enum logic [2:0] {
		E_IDLE  = 3'b001,
		E_ROUND = 3'b010,
		E_FEED  = 3'b100
	} eng_state_t;

	eng_state_t         state_q;
	word_arr_t          w_q;
	word_arr_t          w_step;
	word_arr_t          w_next;
	logic [1:0]         step_q;
	logic [2:0]         qr_q;
	logic [DRC_W-1:0]   dround_q;
	logic [3:0]         ff_q;
	logic [3:0][1:0]    row_amt;
	logic [WORD_W-1:0]  add_a;
	logic [WORD_W-1:0]  add_b;
	logic [WORD_W-1:0]  sum;
	logic [WORD_W-1:0]  mix;
	logic [WORD_W-1:0]  mix_rot;
	logic               last_step;
	logic               last_dround;

	// Rotate each row of the 4x4 state left by its own column count
	function automatic word_arr_t row_rotate(input word_arr_t v, input logic [3:0][1:0] amt);
		word_arr_t  res;
		logic [1:0] col;
		res = v;
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 4; j++) begin
				col = 2'(j) + amt[r];
				res[4*r + j] = v[4*r + int'(col)];
			end
		end
		return res;
	endfunction

	// Shared adder: quarter-round half step, or feed-forward of the input state
	always_comb begin
		if (state_q == E_FEED) begin
			add_a = w_q[0];
			add_b = init[ff_q];
		end else if (!step_q[0]) begin
			add_a = w_q[0];
			add_b = w_q[4];
		end else begin
			add_a = w_q[8];
			add_b = w_q[12];
		end
	end

	assign sum = add_a + add_b;
	assign mix = (step_q[0] ? w_q[4] : w_q[12]) ^ sum;

	// Rotate by 16, 12, 8, 7 for the four steps of a quarter round
	always_comb begin
		unique case (step_q)
			2'd0:    mix_rot = {mix[15:0], mix[31:16]};
			2'd1:    mix_rot = {mix[19:0], mix[31:20]};
			2'd2:    mix_rot = {mix[23:0], mix[31:24]};
			default: mix_rot = {mix[24:0], mix[31:25]};
		endcase
	end

	// Move the next column under the unit; diagonalize after the column round, undo after
	always_comb begin
		if (qr_q == 3'd3) begin
			row_amt = {2'd0, 2'd3, 2'd2, 2'd1};
		end else if (qr_q == 3'd7) begin
			row_amt = {2'd2, 2'd3, 2'd0, 2'd1};
		end else begin
			row_amt = {2'd1, 2'd1, 2'd1, 2'd1};
		end
	end

	assign last_step   = (step_q == 2'd3);
	assign last_dround = (qr_q == 3'd7) && last_step
		&& (dround_q == DRC_W'(dbl_rounds - DR_W'(1)));

	always_comb begin
		w_step = w_q;
		if (!step_q[0]) begin
			w_step[0]  = sum;
			w_step[12] = mix_rot;
		end else begin
			w_step[8] = sum;
			w_step[4] = mix_rot;
		end
		w_next = last_step ? row_rotate(w_step, row_amt) : w_step;
	end

	// Sequencer: rounds, then sixteen feed-forward adds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			step_q   <= '0;
			qr_q     <= '0;
			dround_q <= '0;
			ff_q     <= '0;
		end else if (ctl.abort) begin
			state_q <= E_IDLE;
		end else begin
			unique case (state_q)
				E_IDLE: begin
					if (ctl.start) begin
						step_q   <= '0;
						qr_q     <= '0;
						dround_q <= '0;
						ff_q     <= '0;
						state_q  <= (dbl_rounds == '0) ? E_FEED : E_ROUND;
					end
				end
				E_ROUND: begin
					step_q <= step_q + 2'd1;
					if (last_step) begin
						qr_q <= qr_q + 3'd1;
						if (qr_q == 3'd7) begin
							dround_q <= dround_q + DRC_W'(1);
						end
					end
					if (last_dround) begin
						state_q <= E_FEED;
					end
				end
				E_FEED: begin
					ff_q <= ff_q + 4'd1;
					if (ff_q == 4'd15) begin
						state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	// Working words: load, mix, then shift through the adder for feed-forward
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && ctl.start && !ctl.abort) begin
			w_q <= init;
		end else if (state_q == E_ROUND) begin
			w_q <= w_next;
		end else if (state_q == E_FEED) begin
			for (int i = 0; i < NUM_WORD - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[NUM_WORD-1] <= sum;
		end
	end

	assign stat.busy = (state_q != E_IDLE);
	assign stat.done = (state_q == E_FEED) && (ff_q == 4'd15) && !ctl.abort;
	assign words     = w_q;

endmodule

>>> rtl/chacha_stream_cipher.sv
`timescale 1ns / 1ps

// Stream cipher on the ChaCha quarter round and state layout, with its own block
// constant; one message byte per item: out_byte = in_byte XOR keystream. Keystream
// blocks of 64 bytes are built by one shared 32-bit add/xor/rotate unit that does
// one half step of a quarter round per cycle; after a block is built, its 64 bytes
// go out at up to one item per cycle while the output is not stalled.
// The next block starts the cycle after the 64th byte of the current one is taken.
// Any configuration write restarts the message at the initial counter; after an
// item marked last the counter also returns to its initial value. Write the
// configuration only while no item is in flight.
module chacha_stream_cipher (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           in_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 out_last,
	input  logic                 cfg_we,
	input  ccs_pkg::reg_idx_t    cfg_index,
	input  logic [ccs_pkg::CFG_W-1:0] cfg_data
);
	import ccs_pkg::*;

	logic [3:0][CFG_W-1:0] key_q;
	logic [CFG_W-1:0]      ctr_nonce0_q;
	logic [CFG_W-1:0]      nonce12_q;
	logic [NLEN_W-1:0]     nlen_q;
	logic [RND_W-1:0]      rounds_q;
	logic [WORD_W-1:0]     counter_q;
	logic [POS_W-1:0]      pos_q;
	logic                  ready_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;

	word_arr_t             init;
	word_arr_t             words;
	eng_ctl_t              eng_ctl;
	eng_stat_t             eng_stat;
	logic [DR_W-1:0]       dbl_rounds;
	logic [RND_W:0]        rounds_inc;
	logic [WORD_W-1:0]     ks_word;
	logic [7:0]            ks_byte;
	logic                  in_take;

	// Build the input state
	always_comb begin
		init[0] = SIGMA_0;
		init[1] = SIGMA_1;
		init[2] = SIGMA_2;
		init[3] = SIGMA_3;
		for (int i = 0; i < 4; i++) begin
			init[4 + 2*i] = key_q[i][31:0];
			init[5 + 2*i] = key_q[i][63:32];
		end
		init[12] = counter_q;
		init[13] = (nlen_q > 4'd0) ? ctr_nonce0_q[63:32] : '0;
		init[14] = (nlen_q > 4'd4) ? nonce12_q[31:0]     : '0;
		init[15] = (nlen_q > 4'd8) ? nonce12_q[63:32]    : '0;
	end

	assign rounds_inc = {1'b0, rounds_q} + (RND_W+1)'(1);
	assign dbl_rounds = DR_W'(rounds_inc >> 1);

	// Start a block whenever none is ready and the engine is idle; a config write cancels one in progress
	assign eng_ctl.abort = cfg_we;
	assign eng_ctl.start = !ready_q && !eng_stat.busy && !cfg_we;

	ccs_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (eng_ctl),
		.init       (init),
		.dbl_rounds (dbl_rounds),
		.stat       (eng_stat),
		.words      (words)
	);

	assign ks_word  = words[pos_q[5:2]];
	assign ks_byte  = ks_word[8*pos_q[1:0] +: 8];
	assign in_stall = !(ready_q && (!out_valid_q || !out_stall));
	assign in_take  = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q        <= '0;
			ctr_nonce0_q <= '0;
			nonce12_q    <= '0;
			nlen_q       <= NLEN_RESET;
			rounds_q     <= RND_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_01:     key_q[0]     <= cfg_data;
				REG_KEY_23:     key_q[1]     <= cfg_data;
				REG_KEY_45:     key_q[2]     <= cfg_data;
				REG_KEY_67:     key_q[3]     <= cfg_data;
				REG_CTR_NONCE0: ctr_nonce0_q <= cfg_data;
				REG_NONCE_12:   nonce12_q    <= cfg_data;
				REG_NONCE_LEN:  nlen_q       <= cfg_data[NLEN_W-1:0];
				REG_ROUNDS:     rounds_q     <= cfg_data[RND_W-1:0];
			endcase
		end
	end

	// Block counter, byte position and block-ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			pos_q     <= '0;
			ready_q   <= 1'b0;
		end else if (cfg_we) begin
			counter_q <= (cfg_index == REG_CTR_NONCE0) ? cfg_data[31:0] : ctr_nonce0_q[31:0];
			pos_q     <= '0;
			ready_q   <= 1'b0;
		end else if (in_take) begin
			if (last_byte) begin
				counter_q <= ctr_nonce0_q[31:0];
				pos_q     <= '0;
				ready_q   <= 1'b0;
			end else if (pos_q == POS_W'(63)) begin
				counter_q <= counter_q + 32'd1;
				pos_q     <= '0;
				ready_q   <= 1'b0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end else if (eng_stat.done) begin
			ready_q <= 1'b1;
		end
	end

	// Output register: hold while stalled, load on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			out_byte_q <= in_byte ^ ks_byte;
			out_last_q <= last_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule
